### sv/mpq_pkg.sv
// Shared types and codes for the min priority queue.
// Heap entry layout, result bundle, command and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mpq_pkg;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_POP    = 1'b1;

	localparam logic [1:0] ST_INSERTED  = 2'd0;
	localparam logic [1:0] ST_POPPED    = 2'd1;
	localparam logic [1:0] ST_POP_EMPTY = 2'd2;
	localparam logic [1:0] ST_INS_FULL  = 2'd3;

	localparam int COUNT_W = 11;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] payload;
	} entry_t;

	typedef struct packed {
		logic [31:0]        weight;
		logic [31:0]        value;
		logic [1:0]         status;
		logic [COUNT_W-1:0] count;
	} res_t;

endpackage

`default_nettype wire

### sv/mpq_store.sv
// Heap storage: one write port, two registered read ports.
// Entry format from mpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpq_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [AW-1:0]   waddr,
	input  wire mpq_pkg::entry_t wdata,
	input  wire logic [AW-1:0]   raddr_a,
	input  wire logic [AW-1:0]   raddr_b,
	output mpq_pkg::entry_t      rdata_a,
	output mpq_pkg::entry_t      rdata_b
);
	import mpq_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

### sv/mpq_ctrl.sv
// Heap sequencer: sift-up on insert, sift-down on pop, one level a cycle.
// Drives the mpq_store ports; uses mpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpq_ctrl #(
	parameter int CAPACITY = 1024,
	parameter int AW       = 10,
	parameter int CW       = 11
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire logic            cmd,
	input  wire logic [31:0]     weight,
	input  wire logic [31:0]     value,
	output logic                 res_valid,
	input  wire logic            res_ready,
	output mpq_pkg::res_t        res,
	output logic                 mem_we,
	output logic [AW-1:0]        mem_waddr,
	output mpq_pkg::entry_t      mem_wdata,
	output logic [AW-1:0]        mem_raddr_a,
	output logic [AW-1:0]        mem_raddr_b,
	input  wire mpq_pkg::entry_t mem_rdata_a,
	input  wire mpq_pkg::entry_t mem_rdata_b
);
	import mpq_pkg::*;

	localparam int IW = AW + 2;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_UP    = 3'd1;
	localparam logic [2:0] S_POPLD = 3'd2;
	localparam logic [2:0] S_DOWN  = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;
	localparam logic [2:0] S_RES   = 3'd5;

	logic [2:0]    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [AW-1:0] pos_q, pos_d;
	entry_t        carry_q, carry_d;
	logic [31:0]   ow_q, ow_d, ov_q, ov_d;
	logic [1:0]    st_q, st_d;

	logic [IW-1:0] n_w, left_w, right_w, best_w, nl_w;
	logic [AW-1:0] parent, best;
	logic [AW-1:0] ins_pos;
	logic [31:0]   bkey;
	logic          l_lt, r_lt;
	entry_t        child;
	logic [CW+COUNT_W-1:0] cnt_ext;

	assign n_w     = IW'(cnt_q);
	assign left_w  = {1'b0, pos_q, 1'b1};
	assign right_w = left_w + IW'(1);
	assign parent  = (pos_q - AW'(1)) >> 1;
	assign ins_pos = cnt_q[AW-1:0];

	// child selection: strict compares, left wins a tie
	assign l_lt  = mem_rdata_a.key < carry_q.key;
	assign bkey  = l_lt ? mem_rdata_a.key : carry_q.key;
	assign r_lt  = (right_w < n_w) && (mem_rdata_b.key < bkey);
	assign child = r_lt ? mem_rdata_b : mem_rdata_a;
	assign best_w = r_lt ? right_w : left_w;
	assign best   = best_w[AW-1:0];
	assign nl_w   = {1'b0, best, 1'b1};

	assign cnt_ext = {{COUNT_W{1'b0}}, cnt_q};

	assign in_stall  = (state_q != S_IDLE);
	assign res_valid = (state_q == S_RES);
	assign res       = '{weight: ow_q, value: ov_q, status: st_q,
		count: cnt_ext[COUNT_W-1:0]};

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		pos_d       = pos_q;
		carry_d     = carry_q;
		ow_d        = ow_q;
		ov_d        = ov_q;
		st_d        = st_q;
		mem_we      = 1'b0;
		mem_waddr   = pos_q;
		mem_wdata   = carry_q;
		mem_raddr_a = '0;
		mem_raddr_b = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ow_d = '0;
					ov_d = '0;
					if (cmd == CMD_INSERT) begin
						if (cnt_q == CW'(CAPACITY)) begin
							st_d    = ST_INS_FULL;
							state_d = S_RES;
						end else begin
							st_d    = ST_INSERTED;
							carry_d = '{key: weight, payload: value};
							pos_d   = ins_pos;
							cnt_d   = cnt_q + CW'(1);
							mem_raddr_a = (ins_pos - AW'(1)) >> 1;
							state_d = (cnt_q == '0) ? S_FIN : S_UP;
						end
					end else begin
						if (cnt_q == '0) begin
							st_d    = ST_POP_EMPTY;
							state_d = S_RES;
						end else begin
							st_d        = ST_POPPED;
							mem_raddr_a = '0;
							mem_raddr_b = AW'(cnt_q - CW'(1));
							cnt_d       = cnt_q - CW'(1);
							state_d     = S_POPLD;
						end
					end
				end
			end
			S_UP: begin
				mem_we = 1'b1;
				if (carry_q.key < mem_rdata_a.key) begin
					mem_wdata   = mem_rdata_a;
					pos_d       = parent;
					mem_raddr_a = (parent - AW'(1)) >> 1;
					state_d     = (parent == '0) ? S_FIN : S_UP;
				end else begin
					state_d = S_RES;
				end
			end
			S_POPLD: begin
				ow_d    = mem_rdata_a.key;
				ov_d    = mem_rdata_a.payload;
				carry_d = mem_rdata_b;
				pos_d   = '0;
				mem_raddr_a = AW'(1);
				mem_raddr_b = AW'(2);
				if (cnt_q == '0) begin
					state_d = S_RES;
				end else if (cnt_q == CW'(1)) begin
					state_d = S_FIN;
				end else begin
					state_d = S_DOWN;
				end
			end
			S_DOWN: begin
				mem_we = 1'b1;
				if (l_lt || r_lt) begin
					mem_wdata   = child;
					pos_d       = best;
					mem_raddr_a = nl_w[AW-1:0];
					mem_raddr_b = AW'(nl_w + IW'(1));
					state_d     = (nl_w < n_w) ? S_DOWN : S_FIN;
				end else begin
					state_d = S_RES;
				end
			end
			S_FIN: begin
				mem_we  = 1'b1;
				state_d = S_RES;
			end
			S_RES: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q   <= pos_d;
		carry_q <= carry_d;
		ow_q    <= ow_d;
		ov_q    <= ov_d;
		st_q    <= st_d;
	end

endmodule

`default_nettype wire

### sv/min_priority_queue.sv
// Min priority queue of (weight, value) pairs kept as a binary heap in memory.
// One item at a time. An insert sifts up and a pop sifts down, one read-compare-
// write per heap level walked; a full insert or an empty pop is flagged in the
// status without touching the heap.
// Next item is taken once the result is in the output register.
// Reset clears count and control; heap memory is left uninitialized.
`timescale 1ns / 1ps
`default_nettype none

module min_priority_queue #(
	parameter int CAPACITY = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        cmd,
	input  wire logic [31:0] weight,
	input  wire logic [31:0] value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      out_weight,
	output logic [31:0]      out_value,
	output logic [1:0]       status,
	output logic [10:0]      count
);
	import mpq_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic          res_valid, res_ready;
	res_t          res, out_q;
	logic          out_valid_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;
	entry_t        mem_wdata, mem_rdata_a, mem_rdata_b;

	mpq_ctrl #(
		.CAPACITY(CAPACITY),
		.AW(AW),
		.CW(CW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.weight(weight),
		.value(value),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr_a(mem_raddr_a),
		.mem_raddr_b(mem_raddr_b),
		.mem_rdata_a(mem_rdata_a),
		.mem_rdata_b(mem_rdata_b)
	);

	mpq_store #(
		.DEPTH(CAPACITY),
		.AW(AW)
	) u_store (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr_a(mem_raddr_a),
		.raddr_b(mem_raddr_b),
		.rdata_a(mem_rdata_a),
		.rdata_b(mem_rdata_b)
	);

	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_weight = out_q.weight;
	assign out_value  = out_q.value;
	assign status     = out_q.status;
	assign count      = out_q.count;

endmodule

`default_nettype wire

### sv/mpq_checker.sv
// Port-level checks for min_priority_queue, attached by bind.
// Uses status codes from mpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpq_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] out_weight,
	input wire logic [31:0] out_value,
	input wire logic [1:0]  status,
	input wire logic [10:0] count
);
	import mpq_pkg::*;

	// held result does not move while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_weight) &&
		$stable(out_value) && $stable(status) && $stable(count))
		else $error("result changed while stalled");

	// one item in flight: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted a second item back to back");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_POP_EMPTY |->
		count == '0 && out_weight == '0 && out_value == '0)
		else $error("empty pop with nonzero count or data");

	a_nopop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_INSERTED || status == ST_INS_FULL) |->
		out_weight == '0 && out_value == '0)
		else $error("insert result carries data");

endmodule

bind min_priority_queue mpq_checker u_mpq_checker (.*);

`default_nettype wire

### bench/tb_min_priority_queue.sv
// Self-checking bench for min_priority_queue: directed rows, then random fill/drain.
// Holds its own heap predictor; depends on mpq_pkg and the min_priority_queue RTL.
`timescale 1ns / 1ps

module tb_min_priority_queue;
	import mpq_pkg::*;

	localparam int CAP          = 1024;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 200;
	localparam int QUIET_FROM   = 700;
	localparam int QUIET_TO     = 1000;
	localparam int SETTLE       = 20;
	localparam int MAX_REPORTS  = 10;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        cmd;
	logic [31:0] weight;
	logic [31:0] value;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] out_weight;
	logic [31:0] out_value;
	logic [1:0]  status;
	logic [10:0] count;

	min_priority_queue #(.CAPACITY(CAP)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .weight(weight), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_weight(out_weight), .out_value(out_value),
		.status(status), .count(count)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		#20000000;
		$display("end of test: mismatches");
		$finish;
	end

	// predictor state: heap of (key, payload) plus entry count
	logic [31:0] heap_key [CAP];
	logic [31:0] heap_payload [CAP];
	int          heap_n;

	res_t pending_results [$];
	int   mismatches;
	int   items_taken;
	int   results_seen;

	function automatic void heap_swap(int a, int b);
		logic [31:0] t;
		t = heap_key[a];
		heap_key[a] = heap_key[b];
		heap_key[b] = t;
		t = heap_payload[a];
		heap_payload[a] = heap_payload[b];
		heap_payload[b] = t;
	endfunction

	function automatic res_t heap_apply(logic op, logic [31:0] w, logic [31:0] v);
		res_t r;
		int pos, par, best, lft, rgt;
		r = '0;
		if (op == CMD_INSERT) begin
			if (heap_n >= CAP) begin
				r.status = ST_INS_FULL;
			end else begin
				pos = heap_n;
				heap_key[pos] = w;
				heap_payload[pos] = v;
				heap_n++;
				while (pos > 0) begin
					par = (pos - 1) / 2;
					if (heap_key[pos] < heap_key[par]) begin
						heap_swap(pos, par);
						pos = par;
					end else begin
						break;
					end
				end
				r.status = ST_INSERTED;
			end
		end else if (heap_n == 0) begin
			r.status = ST_POP_EMPTY;
		end else begin
			r.weight = heap_key[0];
			r.value = heap_payload[0];
			heap_n--;
			heap_key[0] = heap_key[heap_n];
			heap_payload[0] = heap_payload[heap_n];
			pos = 0;
			while (1) begin
				best = pos;
				lft = 2 * pos + 1;
				rgt = lft + 1;
				if (lft < heap_n && heap_key[lft] < heap_key[best])
					best = lft;
				if (rgt < heap_n && heap_key[rgt] < heap_key[best])
					best = rgt;
				if (best == pos)
					break;
				heap_swap(pos, best);
				pos = best;
			end
			r.status = ST_POPPED;
		end
		r.count = heap_n[COUNT_W-1:0];
		return r;
	endfunction

	// keys bunch up often so equal weights and extremes get exercised
	function automatic logic [31:0] pick_key();
		case ($urandom_range(9))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2, 3, 4: return $urandom_range(15);
			5: return $urandom_range(255);
			default: return $urandom();
		endcase
	endfunction

	task automatic offer(logic op, logic [31:0] w, logic [31:0] v, logic typed, res_t want);
		res_t r;
		bit quiet;
		quiet = (items_taken >= QUIET_FROM && items_taken < QUIET_TO);
		if (!quiet) begin
			while ($urandom_range(99) < 15) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		cmd <= op;
		weight <= w;
		value <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		r = heap_apply(op, w, v);
		if (typed)
			r = want;
		pending_results.push_back(r);
		items_taken++;
	endtask

	task automatic report(string what, res_t want, res_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%s: expected w=%h v=%h st=%0d cnt=%0d, got w=%h v=%h st=%0d cnt=%0d",
				what, want.weight, want.value, want.status, want.count,
				got.weight, got.value, got.status, got.count);
	endtask

	typedef struct packed {
		logic        op;
		logic [31:0] w;
		logic [31:0] v;
		logic        typed;
		res_t        want;
	} dir_row_t;

	// typed expectations only where the answer is obvious; others go to the predictor
	dir_row_t dir_rows [0:22] = '{
		'{CMD_POP,    32'h0,         32'h0,         1'b1, '{32'h0, 32'h0, ST_POP_EMPTY, 11'd0}},
		'{CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0, 32'h0, ST_INSERTED, 11'd1}},
		'{CMD_INSERT, 32'h0,         32'h0,         1'b1, '{32'h0, 32'h0, ST_INSERTED, 11'd2}},
		'{CMD_INSERT, 32'h0,         32'h1,         1'b1, '{32'h0, 32'h0, ST_INSERTED, 11'd3}},
		'{CMD_INSERT, 32'h7,         32'hAAAA_5555, 1'b1, '{32'h0, 32'h0, ST_INSERTED, 11'd4}},
		'{CMD_INSERT, 32'h7,         32'h5555_AAAA, 1'b1, '{32'h0, 32'h0, ST_INSERTED, 11'd5}},
		'{CMD_INSERT, 32'h7,         32'h3,         1'b1, '{32'h0, 32'h0, ST_INSERTED, 11'd6}},
		'{CMD_POP,    32'h0,         32'h0,         1'b1, '{32'h0, 32'h0, ST_POPPED, 11'd5}},
		'{CMD_POP,    32'h0,         32'h0,         1'b1, '{32'h0, 32'h1, ST_POPPED, 11'd4}},
		'{CMD_POP,    32'h0,         32'h0,         1'b0, '0},
		'{CMD_POP,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
		'{CMD_POP,    32'h0,         32'h0,         1'b0, '0},
		'{CMD_POP,    32'h0,         32'h0,         1'b1,
			'{32'hFFFF_FFFF, 32'hFFFF_FFFF, ST_POPPED, 11'd0}},
		'{CMD_POP,    32'h0,         32'h0,         1'b1, '{32'h0, 32'h0, ST_POP_EMPTY, 11'd0}},
		'{CMD_INSERT, 32'h8000_0000, 32'h1,         1'b1, '{32'h0, 32'h0, ST_INSERTED, 11'd1}},
		'{CMD_INSERT, 32'h1,         32'h8000_0000, 1'b1, '{32'h0, 32'h0, ST_INSERTED, 11'd2}},
		'{CMD_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 1'b1, '{32'h0, 32'h0, ST_INSERTED, 11'd3}},
		'{CMD_INSERT, 32'hFFFF_FFFE, 32'h0,         1'b1, '{32'h0, 32'h0, ST_INSERTED, 11'd4}},
		'{CMD_POP,    32'h0,         32'h0,         1'b1,
			'{32'h1, 32'h8000_0000, ST_POPPED, 11'd3}},
		'{CMD_POP,    32'h0,         32'h0,         1'b1,
			'{32'h7FFF_FFFF, 32'hFFFF_FFFE, ST_POPPED, 11'd2}},
		'{CMD_POP,    32'h0,         32'h0,         1'b1,
			'{32'h8000_0000, 32'h1, ST_POPPED, 11'd1}},
		'{CMD_POP,    32'h0,         32'h0,         1'b1,
			'{32'hFFFF_FFFE, 32'h0, ST_POPPED, 11'd0}},
		'{CMD_POP,    32'h0,         32'h0,         1'b1, '{32'h0, 32'h0, ST_POP_EMPTY, 11'd0}}
	};

	// sender
	initial begin
		int i;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_INSERT;
		weight = '0;
		value = '0;
		heap_n = 0;
		mismatches = 0;
		items_taken = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			offer(dir_rows[i].op, dir_rows[i].w, dir_rows[i].v, dir_rows[i].typed,
				dir_rows[i].want);

		// mixed traffic near empty
		for (i = 0; i < 150; i++)
			offer(($urandom_range(99) < 55) ? CMD_INSERT : CMD_POP, pick_key(), $urandom(),
				1'b0, '0);
		// fill to capacity
		while (heap_n < CAP)
			offer(($urandom_range(99) < 96) ? CMD_INSERT : CMD_POP, pick_key(), $urandom(),
				1'b0, '0);
		// hover at full so inserts bounce
		for (i = 0; i < 40; i++)
			offer(($urandom_range(99) < 70) ? CMD_INSERT : CMD_POP, pick_key(), $urandom(),
				1'b0, '0);
		// drain a good part of it
		for (i = 0; i < 350; i++)
			offer(($urandom_range(99) < 85) ? CMD_POP : CMD_INSERT, pick_key(), $urandom(),
				1'b0, '0);

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (pending_results.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// receiver: checks results, stalls at random, one long hold-off
	initial begin
		res_t got;
		res_t want;
		bit   held;
		int   k;
		out_stall = 1'b0;
		results_seen = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got = {out_weight, out_value, status, count};
				if (pending_results.size() == 0) begin
					report("result with nothing expected", '0, got);
				end else begin
					want = pending_results.pop_front();
					if (got.weight !== want.weight || got.value !== want.value ||
							got.status !== want.status || got.count !== want.count)
						report("mismatch", want, got);
				end
				results_seen++;
			end
			if (results_seen == HOLD_AT && !held) begin
				held = 1'b1;
				out_stall <= 1'b1;
				for (k = 0; k < HOLD_CYCLES; k++)
					@(posedge clk);
				out_stall <= 1'b0;
			end else if (results_seen >= QUIET_FROM && results_seen < QUIET_TO) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < 15);
			end
		end
	end

endmodule
